>>> rtl/core/gde_pkg.sv
// Package for the int8 dot-product engine: sizes, codes, reset values and
// the structs that pass between the store, the MAC array and the result buffer.
// No dependencies.
package gde_pkg;

   localparam int MAX_ROWS  = 16;
   localparam int MAX_DEPTH = 4096;

   // Results are emitted for at most sixteen rows per channel.
   localparam int OUT_ROWS   = (MAX_ROWS < 16) ? MAX_ROWS : 16;
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int OUT_ROW_W  = 4;
   localparam int ROWCNT_W   = $clog2(OUT_ROWS + 1);
   localparam int ADDR_W     = $clog2(MAX_DEPTH);
   localparam int WORD_W     = MAX_ROWS * 8;

   localparam int K_W        = 12;
   localparam int LEN_W      = 13;
   localparam int ACTCFG_W   = 5;
   localparam int CH_W       = 16;
   localparam int ACC_W      = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_WEIGHT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH   = 2'd0,
      CSR_ACTIVE_ROWS  = 2'd1,
      CSR_OUT_CHANNELS = 2'd2
   } csr_index_type;

   localparam logic [LEN_W-1:0]    RESET_ROW_LENGTH   = 13'd4096;
   localparam logic [ACTCFG_W-1:0] RESET_ACTIVE_ROWS  = 5'd16;
   localparam logic [CH_W-1:0]     RESET_OUT_CHANNELS = 16'd2048;

   // Access to the activation store for one accepted item.
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [ROW_W-1:0]  wr_row;
      logic [7:0]        wr_data;
   } gde_store_req_type;

   // One multiply-accumulate step of the MAC array.
   typedef struct packed {
      logic                en;
      logic                last;
      logic [ROWCNT_W-1:0] rows;
   } gde_mac_step_type;

   // Capture of a finished channel into the result buffer.
   typedef struct packed {
      logic                load;
      logic [CH_W-1:0]     channel;
      logic [ROWCNT_W-1:0] rows;
   } gde_snap_type;

endpackage

>>> rtl/core/gde_req_if.sv
// Input channel of the int8 dot-product engine: valid/ready and one item.
// Depends on gde_pkg for field widths.
interface gde_req_if
   import gde_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [3:0]             act_row;
   logic [K_W-1:0]         k_index;
   logic signed [7:0]      value;
   logic                   last;

   modport source (output valid, cmd, act_row, k_index, value, last, input ready);
   modport sink   (input valid, cmd, act_row, k_index, value, last, output ready);
endinterface

>>> rtl/core/gde_rsp_if.sv
// Result channel of the int8 dot-product engine: valid/ready and one item.
// Depends on gde_pkg for field widths.
interface gde_rsp_if
   import gde_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [OUT_ROW_W-1:0]    row;
   logic [CH_W-1:0]         channel;
   logic signed [ACC_W-1:0] dot_value;
   logic                    last_of_run;

   modport source (output valid, row, channel, dot_value, last_of_run, input ready);
   modport sink   (input valid, row, channel, dot_value, last_of_run, output ready);
endinterface

>>> rtl/core/gde_act_store.sv
// Activation store: one word per column holding a byte of every row.
// Byte-lane writes, registered read of a whole column. Depends on gde_pkg.
module gde_act_store
   import gde_pkg::*;
   (
   input  logic              clock,
   input  gde_store_req_type store_req,
   output logic [WORD_W-1:0] column
   );

   logic [WORD_W-1:0] mem [MAX_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.addr][{store_req.wr_row, 3'b000} +: 8] <= store_req.wr_data;
      end
   end

   // The read register only moves when an item is taken, so a stalled
   // weight keeps its column.
   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.addr];
      end
   end

   assign column = rd_data_ff;

endmodule

>>> rtl/core/gde_mac_array.sv
// MAC array: one signed 8x8 multiplier and one 32-bit accumulator per row.
// Gives the updated sums for the result buffer on a channel's last byte.
// Depends on gde_pkg.
module gde_mac_array
   import gde_pkg::*;
   (
   input  logic                            clock,
   input  logic                            reset,
   input  gde_mac_step_type                step,
   input  logic signed [7:0]               weight,
   input  logic [WORD_W-1:0]               column,
   output logic [MAX_ROWS-1:0][ACC_W-1:0]  sums
   );

   logic [ACC_W-1:0] acc_ff [MAX_ROWS];
   logic [ACC_W-1:0] acc_in [MAX_ROWS];

   always_comb begin
      logic signed [15:0] prod;
      for (int s = 0; s < MAX_ROWS; s++) begin
         prod = $signed(column[s*8 +: 8]) * weight;
         // Rows outside the active range do not accumulate.
         if (ROWCNT_W'(s) < step.rows && s < OUT_ROWS) begin
            sums[s] = acc_ff[s] + ACC_W'(prod);
         end else begin
            sums[s] = acc_ff[s];
         end
         if (step.en && step.last) begin
            acc_in[s] = '0;
         end else if (step.en) begin
            acc_in[s] = sums[s];
         end else begin
            acc_in[s] = acc_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < MAX_ROWS; s++) begin
         if (reset) begin
            acc_ff[s] <= '0;
         end else begin
            acc_ff[s] <= acc_in[s];
         end
      end
   end

endmodule

>>> rtl/core/gde_result_buffer.sv
// Result buffer: holds the sums of one finished channel and sends them
// out one row per item, row 0 first. Depends on gde_pkg and gde_rsp_if.
module gde_result_buffer
   import gde_pkg::*;
   (
   input  logic                           clock,
   input  logic                           reset,
   input  gde_snap_type                   snap,
   input  logic [MAX_ROWS-1:0][ACC_W-1:0] sums,
   output logic                           busy,
   gde_rsp_if.source                      rsp
   );

   logic [ACC_W-1:0]     bank_ff [OUT_ROWS];
   logic [CH_W-1:0]      channel_ff;
   logic [ROWCNT_W-1:0]  rows_ff;
   logic [OUT_ROW_W-1:0] idx_ff;
   logic [OUT_ROW_W-1:0] idx_in;
   logic                 valid_ff;
   logic                 valid_in;
   logic                 final_row;
   logic                 rsp_fire;

   assign final_row = (ROWCNT_W'(idx_ff) + ROWCNT_W'(1)) == rows_ff;
   assign rsp_fire  = valid_ff && rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (snap.load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (rsp_fire && final_row) begin
         valid_in = 1'b0;
         idx_in   = '0;
      end else if (rsp_fire) begin
         idx_in   = idx_ff + OUT_ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap.load) begin
         channel_ff <= snap.channel;
         rows_ff    <= snap.rows;
         for (int s = 0; s < OUT_ROWS; s++) begin
            bank_ff[s] <= sums[s];
         end
      end
   end

   assign busy            = valid_ff;
   assign rsp.valid       = valid_ff;
   assign rsp.row         = idx_ff;
   assign rsp.channel     = channel_ff;
   assign rsp.dot_value   = bank_ff[idx_ff];
   assign rsp.last_of_run = final_row;

endmodule

>>> rtl/core/int8_gemm_dot_engine.sv
// Top level of the int8 dot-product engine: configuration registers, weight
// stage, channel counter. Depends on gde_pkg, gde_req_if, gde_rsp_if,
// gde_act_store, gde_mac_array and gde_result_buffer.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    cmd, act_row, k_index, value, last
//   rsp_ch    out        valid/ready    row, channel, dot_value, last_of_run
//   csr       in         csr_we only    csr_index, csr_wdata
//
// One item is taken per cycle unless stalled. A weight reads its store column at
// acceptance and updates the active rows' accumulators. A channel's last byte
// copies the sums into the result buffer, which sends one result per cycle while
// the receiver is ready. If the buffer still holds the previous channel, the
// last byte waits in the weight stage and the input stalls until it empties.
// Reset clears accumulators, channel counter and buffer and presets the
// configuration; the activation store is not cleared and needs no clearing pass.
module int8_gemm_dot_engine
   import gde_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   gde_req_if.sink               req_ch,
   gde_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
   );

   logic [LEN_W-1:0]    row_length_ff;
   logic [ACTCFG_W-1:0] active_rows_ff;
   logic [CH_W-1:0]     out_channels_ff;
   logic [CH_W-1:0]     channel_ff;
   logic [CH_W-1:0]     channel_in;

   logic                s1_valid_ff;
   logic                s1_last_ff;
   logic signed [7:0]   s1_value_ff;

   logic [LEN_W-1:0]    eff_len;
   logic [ROWCNT_W-1:0] eff_rows;
   logic                req_fire;
   logic                weight_ok;
   logic                load_ok;
   logic                stall;
   logic                buf_busy;
   logic [CH_W:0]       channel_next;

   gde_store_req_type              store_req;
   gde_mac_step_type               step;
   gde_snap_type                   snap;
   logic [WORD_W-1:0]              column;
   logic [MAX_ROWS-1:0][ACC_W-1:0] sums;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff   <= RESET_ROW_LENGTH;
         active_rows_ff  <= RESET_ACTIVE_ROWS;
         out_channels_ff <= RESET_OUT_CHANNELS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_LENGTH:   row_length_ff   <= csr_wdata[LEN_W-1:0];
            CSR_ACTIVE_ROWS:  active_rows_ff  <= csr_wdata[ACTCFG_W-1:0];
            CSR_OUT_CHANNELS: out_channels_ff <= csr_wdata[CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(row_length_ff) > MAX_DEPTH) begin
         eff_len = LEN_W'(MAX_DEPTH);
      end else begin
         eff_len = row_length_ff;
      end
      if (active_rows_ff == '0) begin
         eff_rows = ROWCNT_W'(1);
      end else if (32'(active_rows_ff) > OUT_ROWS) begin
         eff_rows = ROWCNT_W'(OUT_ROWS);
      end else begin
         eff_rows = ROWCNT_W'(active_rows_ff);
      end
   end

   // A channel's last byte cannot leave the weight stage while the result
   // buffer still holds the previous channel.
   assign stall        = s1_valid_ff && s1_last_ff && buf_busy;
   assign req_ch.ready = !stall;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign weight_ok = (req_ch.cmd == CMD_WEIGHT) && (LEN_W'(req_ch.k_index) < eff_len);
   assign load_ok   = (req_ch.cmd == CMD_LOAD) && (32'(req_ch.act_row) < MAX_ROWS)
                      && (32'(req_ch.k_index) < MAX_DEPTH);

   always_comb begin
      store_req.rd_en   = req_fire;
      store_req.wr_en   = req_fire && load_ok;
      store_req.addr    = req_ch.k_index[ADDR_W-1:0];
      store_req.wr_row  = ROW_W'(req_ch.act_row);
      store_req.wr_data = req_ch.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= req_fire && weight_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_last_ff  <= req_ch.last;
         s1_value_ff <= req_ch.value;
      end
   end

   always_comb begin
      step.en      = s1_valid_ff && !stall;
      step.last    = s1_last_ff;
      step.rows    = eff_rows;
      snap.load    = step.en && s1_last_ff;
      snap.channel = channel_ff;
      snap.rows    = eff_rows;
   end

   assign channel_next = {1'b0, channel_ff} + (CH_W + 1)'(1);

   always_comb begin
      channel_in = channel_ff;
      if (snap.load) begin
         if (channel_next >= {1'b0, out_channels_ff}) begin
            channel_in = '0;
         end else begin
            channel_in = channel_next[CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= '0;
      end else begin
         channel_ff <= channel_in;
      end
   end

   gde_act_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .column    (column)
   );

   gde_mac_array u_mac (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .weight (s1_value_ff),
      .column (column),
      .sums   (sums)
   );

   gde_result_buffer u_buf (
      .clock (clock),
      .reset (reset),
      .snap  (snap),
      .sums  (sums),
      .busy  (buf_busy),
      .rsp   (rsp_ch)
   );

endmodule

>>> rtl/core/gde_checker.sv
// Port-level checks for the int8 dot-product engine, bound to the top level.
// Depends on gde_pkg and on the top level's ports.
module gde_checker
   import gde_pkg::*;
   (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [OUT_ROW_W-1:0]    row,
   input logic [CH_W-1:0]         channel,
   input logic [ACC_W-1:0]        dot_value,
   input logic                    last_of_run
   );

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A waiting result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // A waiting result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(row) && $stable(channel)
                                  && $stable(dot_value) && $stable(last_of_run))
      else $error("result payload changed while stalled");

   // Within a burst the rows follow one another for the same channel.
   a_burst_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !last_of_run |=> rsp_valid && row == $past(row) + OUT_ROW_W'(1)
                                   && channel == $past(channel))
      else $error("burst row sequence broken");

   // The buffer empties after the final result of a burst.
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && last_of_run |=> !rsp_valid)
      else $error("result offered right after the end of a burst");

   // A burst starts at row zero.
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> row == '0)
      else $error("burst does not start at row zero");

endmodule

bind int8_gemm_dot_engine gde_checker u_gde_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .row         (rsp_ch.row),
   .channel     (rsp_ch.channel),
   .dot_value   (rsp_ch.dot_value),
   .last_of_run (rsp_ch.last_of_run)
);

>>> dv/testbench.sv
// Testbench for int8_gemm_dot_engine: random and directed activation loads
// and weight streams, checked against a cycle-free predictor of the dot sums.
// Depends on gde_pkg, gde_req_if, gde_rsp_if and the engine RTL.
module testbench;
   import gde_pkg::*;

   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int LONG_HOLD      = 600;
   localparam int RANDOM_ITEMS   = 450;
   // Room left for the pressure phase and for weights beyond the row length.
   localparam int RESERVED_ITEMS = 150;

   typedef struct packed {
      logic              cmd;
      logic [3:0]        act_row;
      logic [K_W-1:0]    k_index;
      logic signed [7:0] value;
      logic              last;
   } engine_item_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0]    row;
      logic [CH_W-1:0]         channel;
      logic signed [ACC_W-1:0] dot;
      logic                    last;
   } engine_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic            drv_valid = 1'b0;
   engine_item_type drv_item = '0;
   engine_item_type on_bus = '0;
   logic            rsp_ready_r = 1'b0;

   gde_req_if req_ch ();
   gde_rsp_if rsp_ch ();

   assign req_ch.valid   = drv_valid;
   assign req_ch.cmd     = drv_item.cmd;
   assign req_ch.act_row = drv_item.act_row;
   assign req_ch.k_index = drv_item.k_index;
   assign req_ch.value   = drv_item.value;
   assign req_ch.last    = drv_item.last;
   assign rsp_ch.ready   = rsp_ready_r;

   int8_gemm_dot_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state and the configuration it runs under.
   logic [LEN_W-1:0]        cfg_row_length = RESET_ROW_LENGTH;
   logic [ACTCFG_W-1:0]     cfg_active_rows = RESET_ACTIVE_ROWS;
   logic [CH_W-1:0]         cfg_out_channels = RESET_OUT_CHANNELS;
   logic signed [7:0]       act_mem [MAX_ROWS][MAX_DEPTH];
   logic signed [ACC_W-1:0] row_acc [MAX_ROWS];
   logic [CH_W-1:0]         chan_count = '0;

   // Which store entries the stimulus has written so far.
   bit col_written [MAX_ROWS][MAX_DEPTH];

   engine_item_type   pending_bytes [$];
   engine_result_type expected_dots [$];

   int stim_count = 0;
   int accepted = 0;
   int checked = 0;
   int failures = 0;
   int config_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_trigger = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   initial begin
      for (int s = 0; s < MAX_ROWS; s++) row_acc[s] = '0;
   end

   function automatic int unsigned usable_length();
      return (cfg_row_length > MAX_DEPTH) ? MAX_DEPTH : cfg_row_length;
   endfunction

   function automatic int unsigned usable_rows();
      int unsigned lim;
      lim = (MAX_ROWS < 16) ? MAX_ROWS : 16;
      if (cfg_active_rows == 0) return 1;
      if (cfg_active_rows > lim) return lim;
      return cfg_active_rows;
   endfunction

   function automatic void accumulate_byte(engine_item_type it);
      int unsigned nrows;
      logic signed [ACC_W-1:0] prod;
      logic [CH_W:0] nxt;
      engine_result_type r;
      if (it.cmd == CMD_LOAD) begin
         act_mem[it.act_row][it.k_index] = it.value;
         return;
      end
      if (it.k_index >= usable_length()) return;
      nrows = usable_rows();
      for (int s = 0; s < nrows; s++) begin
         prod = act_mem[s][it.k_index] * it.value;
         row_acc[s] = row_acc[s] + prod;
      end
      if (!it.last) return;
      for (int s = 0; s < nrows; s++) begin
         r.row = OUT_ROW_W'(s);
         r.channel = chan_count;
         r.dot = row_acc[s];
         r.last = (s == nrows - 1);
         expected_dots.push_back(r);
      end
      // A finished channel clears every accumulator, active or not.
      for (int s = 0; s < MAX_ROWS; s++) row_acc[s] = '0;
      nxt = {1'b0, chan_count} + 1'b1;
      chan_count = (nxt >= {1'b0, cfg_out_channels}) ? '0 : nxt[CH_W-1:0];
   endfunction

   function automatic bit column_ready(int unsigned k, int unsigned nrows);
      for (int s = 0; s < nrows; s++)
         if (!col_written[s][k]) return 1'b0;
      return 1'b1;
   endfunction

   // Mostly a loaded column of this pass; now and then any column that is
   // safe to read or that the engine will ignore.
   function automatic int unsigned pick_column(int unsigned lused, int unsigned effl,
                                               int unsigned effr);
      int unsigned k;
      if ($urandom_range(9) == 0) begin
         k = $urandom_range(MAX_DEPTH - 1);
         if (k >= effl || column_ready(k, effr)) return k;
      end
      return $urandom_range(lused - 1);
   endfunction

   task automatic push_load(input int unsigned row, input int unsigned k,
                            input logic signed [7:0] v, input logic lst);
      engine_item_type it;
      it.cmd = CMD_LOAD;
      it.act_row = 4'(row);
      it.k_index = K_W'(k);
      it.value = v;
      it.last = lst;
      pending_bytes.push_back(it);
      col_written[row][k] = 1'b1;
      stim_count++;
   endtask

   task automatic push_weight(input int unsigned k, input logic signed [7:0] v,
                              input logic lst);
      engine_item_type it;
      it.cmd = CMD_WEIGHT;
      it.act_row = 4'($urandom_range(15));
      it.k_index = K_W'(k);
      it.value = v;
      it.last = lst;
      pending_bytes.push_back(it);
      if (k < usable_length()) stim_count++;
   endtask

   // Returns at a falling edge once nothing is in flight.
   task automatic wait_until_idle();
      while (pending_bytes.size() != 0 || drv_valid || expected_dots.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [LEN_W-1:0] len, input logic [ACTCFG_W-1:0] rows,
                             input logic [CH_W-1:0] chans);
      logic [CSR_DATA_W-1:0] data;
      wait_until_idle();
      data = CSR_DATA_W'($urandom);
      data[LEN_W-1:0] = len;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ROW_LENGTH;
      csr_wdata <= data;
      data = CSR_DATA_W'($urandom);
      data[ACTCFG_W-1:0] = rows;
      @(posedge clock);
      csr_index <= CSR_ACTIVE_ROWS;
      csr_wdata <= data;
      @(posedge clock);
      csr_index <= CSR_OUT_CHANNELS;
      csr_wdata <= chans;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_row_length = len;
      cfg_active_rows = rows;
      cfg_out_channels = chans;
      config_count++;
      @(negedge clock);
   endtask

   task automatic random_phase();
      logic [LEN_W-1:0] len;
      logic [ACTCFG_W-1:0] rows;
      logic [CH_W-1:0] chans;
      int unsigned effl, effr, lused, n_ch, n_terms;
      case ($urandom_range(9))
         0: len = 0;
         1: len = 1;
         2: len = 4096;
         3: len = LEN_W'($urandom_range(8191, 4097));
         4: len = 8191;
         default: len = LEN_W'($urandom_range(12, 2));
      endcase
      case ($urandom_range(7))
         0: rows = 0;
         1: rows = 1;
         2: rows = 16;
         3: rows = ACTCFG_W'($urandom_range(31, 17));
         default: rows = ACTCFG_W'($urandom_range(15, 2));
      endcase
      case ($urandom_range(7))
         0: chans = 0;
         1: chans = 1;
         2: chans = 16'hFFFF;
         3: chans = 2048;
         default: chans = CH_W'($urandom_range(6, 2));
      endcase
      set_config(len, rows, chans);
      effl = usable_length();
      effr = usable_rows();
      lused = (effl == 0) ? 0 : $urandom_range((effl < 4) ? effl : 4, 1);

      for (int s = 0; s < effr; s++)
         for (int k = 0; k < lused; k++)
            if (!col_written[s][k] || $urandom_range(1))
               push_load(s, k, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(3))
         push_load($urandom_range(15), $urandom_range(MAX_DEPTH - 1), 8'($urandom),
                   1'($urandom));

      n_ch = $urandom_range(6, 2);
      for (int c = 0; c < n_ch; c++) begin
         if (lused == 0) begin
            // Every weight is out of range here, last flag included.
            push_weight($urandom_range(MAX_DEPTH - 1), 8'($urandom), 1'($urandom));
         end else begin
            n_terms = $urandom_range(lused + 2, 1);
            for (int t = 0; t < n_terms; t++) begin
               if (effl < MAX_DEPTH && $urandom_range(5) == 0)
                  push_weight($urandom_range(MAX_DEPTH - 1, effl), 8'($urandom),
                              1'($urandom));
               if ($urandom_range(9) == 0)
                  push_load($urandom_range(15), $urandom_range(MAX_DEPTH - 1),
                            8'($urandom), 1'($urandom));
               push_weight(pick_column(lused, effl, effr), 8'($urandom), t == n_terms - 1);
            end
         end
      end
   endtask

   // The receiver stalls for a long stretch while full sixteen-row channels
   // keep arriving, so the result buffer and then the input back up.
   task automatic pressure_phase();
      set_config(4, 16, 1000);
      for (int s = 0; s < 16; s++)
         for (int k = 0; k < 4; k++)
            push_load(s, k, 8'($urandom), 1'b0);
      wait_until_idle();
      hold_trigger = ~hold_trigger;
      for (int c = 0; c < 12; c++) begin
         push_weight(0, 8'($urandom), 1'b0);
         push_weight(1, 8'($urandom), 1'b1);
      end
      // Nothing more is offered until every result of the burst is back.
      wait_until_idle();
      for (int c = 0; c < 3; c++)
         push_weight($urandom_range(3), 8'($urandom), 1'b1);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_ch.ready) begin
            accumulate_byte(on_bus);
            accepted++;
         end
         if (!drv_valid || req_ch.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_bytes.pop_front();
               drv_item <= on_bus;
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : result_monitor
      engine_result_type want;
      if (reset) begin
         rsp_ready_r <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready_r) begin
            if (expected_dots.size() == 0) begin
               $display("%0t: result with none expected: row %0d channel %0d dot %0d last %0b",
                        $time, rsp_ch.row, rsp_ch.channel, rsp_ch.dot_value,
                        rsp_ch.last_of_run);
               failures++;
            end else begin
               want = expected_dots.pop_front();
               if (rsp_ch.row !== want.row || rsp_ch.channel !== want.channel ||
                   rsp_ch.dot_value !== want.dot || rsp_ch.last_of_run !== want.last) begin
                  $display("%0t: mismatch: expected row %0d channel %0d dot %0d last %0b",
                           $time, want.row, want.channel, want.dot, want.last);
                  $display("%0t:           actual row %0d channel %0d dot %0d last %0b",
                           $time, rsp_ch.row, rsp_ch.channel, rsp_ch.dot_value,
                           rsp_ch.last_of_run);
                  failures++;
               end
               checked++;
            end
         end
         rsp_ready_r <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timed out with %0d results outstanding", $time, expected_dots.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extreme values at the first and last column, loads carrying a last
      // flag, a one-term channel and a wrap of the channel counter.
      set_config(4096, 2, 2);
      push_load(0, 0, -8'sd128, 1'b0);
      push_load(0, MAX_DEPTH - 1, 8'sd127, 1'b1);
      push_load(1, 0, 8'sd127, 1'b0);
      push_load(1, MAX_DEPTH - 1, -8'sd128, 1'b1);
      push_weight(0, -8'sd128, 1'b0);
      push_weight(MAX_DEPTH - 1, 8'sd127, 1'b1);
      push_weight(MAX_DEPTH - 1, -8'sd128, 1'b1);
      push_weight(0, 8'sd127, 1'b1);
      // One-element rows: a weight beyond the row is dropped with its last flag.
      // Zero active rows behaves as one row.
      set_config(1, 0, 2);
      push_weight(MAX_DEPTH - 1, 8'sd127, 1'b1);
      push_weight(0, -8'sd128, 1'b1);
      // Zero row length drops every weight.
      set_config(0, 17, 0);
      push_weight(0, 8'sd127, 1'b1);
      // All sixteen rows, oversized length and channel count.
      set_config(8191, 31, 16'hFFFF);
      for (int s = 2; s < 16; s++)
         push_load(s, 0, (s % 2) ? 8'sd127 : -8'sd128, 1'b0);
      push_weight(0, -8'sd128, 1'b1);

      for (int regime = 0; regime < 3; regime++) begin
         wait_until_idle();
         case (regime)
            0: begin send_idle_pct = 32; recv_idle_pct = 53; end
            1: begin send_idle_pct = 53; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         while (stim_count < 25 + ((RANDOM_ITEMS - RESERVED_ITEMS) * (regime + 1)) / 3)
            random_phase();
         if (regime == 2) pressure_phase();
      end

      wait_until_idle();
      $display("Sent %0d items, checked %0d results across %0d register settings,",
               accepted, checked, config_count);
      $display("with sender and receiver stalls and one long receiver hold-off.");
      if (failures == 0 && expected_dots.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
